@@ src/mec_pkg.sv @@
package mec_pkg;

    localparam int IN_W       = 20;
    localparam int ITER_OUT_W = 7;
    localparam int RGBA_W     = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;
    localparam int M_PAD_W    = M_TDATA_W - ITER_OUT_W - RGBA_W;

    localparam logic [7:0]        ALPHA        = 8'hFF;
    localparam logic [7:0]        CHAN_MAX     = 8'hFF;
    localparam logic [RGBA_W-1:0] OPAQUE_BLACK = 32'hFF00_0000;

    // ramp segments, picked by the top two bits of t
    localparam logic [1:0] SEG_BLUE   = 2'd0;
    localparam logic [1:0] SEG_CYAN   = 2'd1;
    localparam logic [1:0] SEG_YELLOW = 2'd2;
    localparam logic [1:0] SEG_RED    = 2'd3;

    typedef struct packed {
        logic valid;
        logic done;     // point has escaped, z is frozen
    } t_flags;

    // t is below 255, so 4*(t mod 64) never exceeds a channel
    function automatic logic [RGBA_W-1:0] ramp_colour(input logic [7:0] t);
        logic [7:0] step;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        step = {t[5:0], 2'b00};
        r    = '0;
        g    = '0;
        b    = '0;
        unique case (t[7:6])
            SEG_BLUE: begin
                b = step;
            end
            SEG_CYAN: begin
                g = step;
                b = CHAN_MAX;
            end
            SEG_YELLOW: begin
                r = step;
                g = CHAN_MAX;
                b = CHAN_MAX - step;
            end
            SEG_RED: begin
                r = CHAN_MAX;
                g = CHAN_MAX - step;
            end
            default: begin
                r = '0;
            end
        endcase
        return {ALPHA, b, g, r};
    endfunction

endpackage

@@ src/mandelbrot_escape_color.sv @@
// Mandelbrot escape-time colouring, one point per request. Each input request
// carries c as two signed fixed-point coordinates (FRAC_BITS fraction bits);
// z = z*z + c is iterated from zero with products rounded toward minus
// infinity, stopping when |z|^2 exceeds 4.0 or after ITER_LIMIT steps. The
// result request gives the step count and an RGBA colour (opaque black for
// points in the set). The iteration loop is fully unrolled: every step has
// its own multiply stage and add/compare stage, so one point is taken every
// cycle while the output is not stalled; its result passes through
// 2*ITER_LIMIT+1 register stages including the output register.
// The whole pipeline holds while the output register waits on i_m_tready, so
// each such stall delays every point in flight.
module mandelbrot_escape_color #(
    parameter int ITER_LIMIT = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [19:0] point_re, [39:20] point_im
    input  logic [mec_pkg::S_TDATA_W-1:0]    i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [6:0] iterations, [38:7] rgba, [39] zero
    output logic [mec_pkg::M_TDATA_W-1:0]    o_m_tdata
);
    import mec_pkg::*;

    localparam int ZW = ((IN_W > FRAC_BITS + 4) ? IN_W : FRAC_BITS + 4) + 2;
    localparam int CW = $clog2(ITER_LIMIT + 1);

    logic en;

    t_flags                 flags [ITER_LIMIT+1];
    logic [CW-1:0]          cnt   [ITER_LIMIT+1];
    logic [RGBA_W-1:0]      rgba  [ITER_LIMIT+1];
    logic signed [ZW-1:0]   zx    [ITER_LIMIT+1];
    logic signed [ZW-1:0]   zy    [ITER_LIMIT+1];
    logic signed [IN_W-1:0] cre   [ITER_LIMIT+1];
    logic signed [IN_W-1:0] cim   [ITER_LIMIT+1];

    logic                    r_o_valid;
    logic [ITER_OUT_W-1:0]   r_o_iter;
    logic [RGBA_W-1:0]       r_o_rgba;
    logic [ITER_OUT_W-1:0]   n_iter;
    logic [RGBA_W-1:0]       n_rgba;

    assign en         = !r_o_valid || i_m_tready;
    assign o_s_tready = en;

    assign flags[0].valid = i_s_tvalid;
    assign flags[0].done  = 1'b0;
    assign cnt[0]         = '0;
    assign rgba[0]        = '0;
    assign zx[0]          = '0;
    assign zy[0]          = '0;
    assign cre[0]         = $signed(i_s_tdata[IN_W-1:0]);
    assign cim[0]         = $signed(i_s_tdata[2*IN_W-1:IN_W]);

    for (genvar k = 0; k < ITER_LIMIT; k++) begin : g_iter
        mec_iter_stage #(
            .STAGE      (k),
            .ITER_LIMIT (ITER_LIMIT),
            .FRAC_BITS  (FRAC_BITS),
            .ZW         (ZW),
            .CW         (CW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_flags (flags[k]),
            .i_cnt   (cnt[k]),
            .i_rgba  (rgba[k]),
            .i_zx    (zx[k]),
            .i_zy    (zy[k]),
            .i_cre   (cre[k]),
            .i_cim   (cim[k]),
            .o_flags (flags[k+1]),
            .o_cnt   (cnt[k+1]),
            .o_rgba  (rgba[k+1]),
            .o_zx    (zx[k+1]),
            .o_zy    (zy[k+1]),
            .o_cre   (cre[k+1]),
            .o_cim   (cim[k+1])
        );
    end

    // points that never escaped are in the set
    always_comb begin
        if (flags[ITER_LIMIT].done) begin
            n_iter = ITER_OUT_W'(cnt[ITER_LIMIT]);
            n_rgba = rgba[ITER_LIMIT];
        end else begin
            n_iter = ITER_OUT_W'(ITER_LIMIT);
            n_rgba = OPAQUE_BLACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= flags[ITER_LIMIT].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_iter <= n_iter;
            r_o_rgba <= n_rgba;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {M_PAD_W'(0), r_o_rgba, r_o_iter};

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_m_tready) |=> (r_o_valid && $stable(r_o_iter) && $stable(r_o_rgba)))
        else $error("result dropped while stalled");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && flags[ITER_LIMIT].valid) |=> r_o_valid)
        else $error("finished point did not reach the output");

    a_alpha_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_rgba[RGBA_W-1 -: 8] == ALPHA))
        else $error("alpha byte not opaque");

endmodule

@@ src/mec_iter_stage.sv @@
module mec_iter_stage #(
    parameter int STAGE      = 0,
    parameter int ITER_LIMIT = 64,
    parameter int FRAC_BITS  = 16,
    parameter int ZW         = 22,
    parameter int CW         = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  mec_pkg::t_flags                   i_flags,
    input  logic [CW-1:0]                     i_cnt,
    input  logic [mec_pkg::RGBA_W-1:0]        i_rgba,
    input  logic signed [ZW-1:0]              i_zx,
    input  logic signed [ZW-1:0]              i_zy,
    input  logic signed [mec_pkg::IN_W-1:0]   i_cre,
    input  logic signed [mec_pkg::IN_W-1:0]   i_cim,
    output mec_pkg::t_flags                   o_flags,
    output logic [CW-1:0]                     o_cnt,
    output logic [mec_pkg::RGBA_W-1:0]        o_rgba,
    output logic signed [ZW-1:0]              o_zx,
    output logic signed [ZW-1:0]              o_zy,
    output logic signed [mec_pkg::IN_W-1:0]   o_cre,
    output logic signed [mec_pkg::IN_W-1:0]   o_cim
);
    import mec_pkg::*;

    localparam int PW = 2 * ZW - FRAC_BITS;
    localparam int T_STAGE = (STAGE * 255) / ITER_LIMIT;
    localparam logic [RGBA_W-1:0] COLOUR = ramp_colour(8'(T_STAGE));
    localparam logic signed [PW:0] ESC_BOUND = (PW + 1)'(longint'(4) << FRAC_BITS);

    // multiply half
    logic signed [2*ZW-1:0] p_xx;
    logic signed [2*ZW-1:0] p_yy;
    logic signed [2*ZW-1:0] p_xy;

    t_flags                   r_a_flags;
    logic [CW-1:0]            r_a_cnt;
    logic [RGBA_W-1:0]        r_a_rgba;
    logic signed [ZW-1:0]     r_a_zx;
    logic signed [ZW-1:0]     r_a_zy;
    logic signed [IN_W-1:0]   r_a_cre;
    logic signed [IN_W-1:0]   r_a_cim;
    logic signed [PW-1:0]     r_a_sx;
    logic signed [PW-1:0]     r_a_sy;
    logic signed [PW-1:0]     r_a_sxy;

    assign p_xx = i_zx * i_zx;
    assign p_yy = i_zy * i_zy;
    assign p_xy = i_zx * i_zy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_flags <= '0;
        end else if (i_en) begin
            r_a_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_cnt  <= i_cnt;
            r_a_rgba <= i_rgba;
            r_a_zx   <= i_zx;
            r_a_zy   <= i_zy;
            r_a_cre  <= i_cre;
            r_a_cim  <= i_cim;
            r_a_sx   <= PW'(p_xx >>> FRAC_BITS);
            r_a_sy   <= PW'(p_yy >>> FRAC_BITS);
            r_a_sxy  <= PW'(p_xy >>> FRAC_BITS);
        end
    end

    // escape test and update half
    logic signed [PW:0]   mag;
    logic                 esc;
    t_flags               n_flags;
    logic [CW-1:0]        n_cnt;
    logic [RGBA_W-1:0]    n_rgba;
    logic signed [ZW-1:0] n_zx;
    logic signed [ZW-1:0] n_zy;

    t_flags               r_b_flags;
    logic [CW-1:0]        r_b_cnt;
    logic [RGBA_W-1:0]    r_b_rgba;
    logic signed [ZW-1:0] r_b_zx;
    logic signed [ZW-1:0] r_b_zy;
    logic signed [IN_W-1:0] r_b_cre;
    logic signed [IN_W-1:0] r_b_cim;

    assign mag = (PW + 1)'(r_a_sx) + (PW + 1)'(r_a_sy);
    assign esc = mag > ESC_BOUND;

    always_comb begin
        n_flags.valid = r_a_flags.valid;
        n_flags.done  = r_a_flags.done;
        n_cnt         = r_a_cnt;
        n_rgba        = r_a_rgba;
        n_zx          = r_a_zx;
        n_zy          = r_a_zy;
        priority if (r_a_flags.done) begin
            n_flags.done = 1'b1;
        end else if (esc) begin
            n_flags.done = 1'b1;
            n_cnt        = CW'(STAGE);
            n_rgba       = COLOUR;
        end else begin
            // bounded by the test, so truncation to ZW is exact
            n_zx = ZW'(r_a_sx - r_a_sy + PW'(r_a_cre));
            n_zy = ZW'((r_a_sxy <<< 1) + PW'(r_a_cim));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_flags <= '0;
        end else if (i_en) begin
            r_b_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_cnt  <= n_cnt;
            r_b_rgba <= n_rgba;
            r_b_zx   <= n_zx;
            r_b_zy   <= n_zy;
            r_b_cre  <= r_a_cre;
            r_b_cim  <= r_a_cim;
        end
    end

    assign o_flags = r_b_flags;
    assign o_cnt   = r_b_cnt;
    assign o_rgba  = r_b_rgba;
    assign o_zx    = r_b_zx;
    assign o_zy    = r_b_zy;
    assign o_cre   = r_b_cre;
    assign o_cim   = r_b_cim;

    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_a_flags.valid && r_a_flags.done) |=> r_b_flags.done)
        else $error("escaped point lost its done flag");

    a_escape_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_a_flags.valid && !r_a_flags.done && esc)
            |=> (r_b_flags.done && r_b_cnt == CW'(STAGE) && r_b_rgba == COLOUR))
        else $error("escape not recorded at this stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_a_flags) && $stable(r_b_flags)))
        else $error("stage moved during stall");

endmodule
